/* sv/bir_pkg.sv */
// Shared types and constants of the bus interface register block.
`default_nettype none
package bir_pkg;

  typedef enum logic [2:0] {
    CMD_READ        = 3'd0,
    CMD_WRITE       = 3'd1,
    CMD_ERROR       = 3'd2,
    CMD_DBG_STATUS  = 3'd3,
    CMD_NXM_INHIBIT = 3'd4,
    CMD_BUS_RESET   = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    ACT_NONE        = 4'd0,
    ACT_REMOTE_RD   = 4'd1,
    ACT_REMOTE_WR   = 4'd2,
    ACT_REMOTE_CMD  = 4'd3,
    ACT_MARK_DBGR   = 4'd4,
    ACT_MARK_DBGEE  = 4'd5,
    ACT_PING        = 4'd6,
    ACT_RESET_REQ   = 4'd7,
    ACT_INHIBIT_REQ = 4'd8
  } act_t;

  localparam logic [1:0] EK_XBUS_NXM   = 2'd0;
  localparam logic [1:0] EK_UNIBUS_NXM = 2'd1;
  localparam logic [1:0] EK_MAP_ERROR  = 2'd2;

  localparam logic [17:0] ADDR_INT_STATUS   = 18'o766040;
  localparam logic [17:0] ADDR_INT_HIGH     = 18'o766042;
  localparam logic [17:0] ADDR_ERR_STATUS   = 18'o766044;
  localparam logic [17:0] ADDR_DATA         = 18'o766100;
  localparam logic [17:0] ADDR_REMOTE_CMD   = 18'o766102;
  localparam logic [17:0] ADDR_DEBUGGEE_ERR = 18'o766104;
  localparam logic [17:0] ADDR_MODIFIER     = 18'o766110;
  localparam logic [17:0] ADDR_LOCAL_CMD    = 18'o766112;
  localparam logic [17:0] ADDR_WORD_ADDR    = 18'o766114;

  localparam logic [15:0] MASK_LOW_WRITE  = 16'o036001;
  localparam logic [15:0] MASK_HIGH_WRITE = 16'o101774;

  localparam logic [5:0] BIT_XBUS_NXM   = 6'o01;
  localparam logic [5:0] BIT_UNIBUS_NXM = 6'o10;
  localparam logic [5:0] BIT_MAP_ERROR  = 6'o40;

  typedef struct packed {
    act_t        act0;
    act_t        act1;
    logic [15:0] val0;
    logic [15:0] val1;
    logic        two;
    logic [17:0] raddr;
    logic [15:0] rd;
    logic [5:0]  err;
    logic [15:0] intv;
  } rec_t;

  typedef struct packed {
    logic valid;
    rec_t rec;
  } push_t;

  typedef struct packed {
    logic valid;
    rec_t rec;
  } head_t;

endpackage
`default_nettype wire

/* sv/bir_front.sv */
// Front end: accept bus operations, update register state, build result records.
`default_nettype none
module bir_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [55:0]    in_tdata,
  input  logic [2:0]     in_tuser,
  input  logic           q_ready,
  output bir_pkg::push_t push
);
  import bir_pkg::*;

  logic [2:0]  cmd;
  logic [17:0] addr;
  logic [15:0] data;
  logic [1:0]  kind;
  logic [15:0] rdata;
  logic        rok;

  logic [5:0]  err_r, err_nxt;
  logic [15:0] dbg_err_r, dbg_err_nxt;
  logic        inh_r, inh_nxt;
  logic        rst_seen_r, rst_seen_nxt;
  logic        hab_r, hab_nxt;
  logic [15:0] wa_r, wa_nxt;
  logic [15:0] int_r, int_nxt;
  rec_t        rec;

  assign cmd   = in_tuser;
  assign addr  = in_tdata[17:0];
  assign data  = in_tdata[33:18];
  assign kind  = in_tdata[35:34];
  assign rdata = in_tdata[51:36];
  assign rok   = in_tdata[52];

  assign in_tready  = q_ready;
  assign push.valid = in_tvalid && q_ready;
  assign push.rec   = rec;

  always_comb begin
    err_nxt      = err_r;
    dbg_err_nxt  = dbg_err_r;
    inh_nxt      = inh_r;
    rst_seen_nxt = rst_seen_r;
    hab_nxt      = hab_r;
    wa_nxt       = wa_r;
    int_nxt      = int_r;
    rec.act0     = ACT_NONE;
    rec.act1     = ACT_NONE;
    rec.val0     = '0;
    rec.val1     = '0;
    rec.two      = 1'b0;
    rec.rd       = '0;
    unique case (cmd)
      CMD_READ: begin
        priority if (addr == ADDR_INT_STATUS) begin
          rec.rd = int_r;
        end else if (addr == ADDR_ERR_STATUS) begin
          rec.rd = {10'd0, err_r};
        end else if (addr == ADDR_DATA) begin
          rec.act0 = ACT_REMOTE_RD;
          rec.rd   = rok ? rdata : 16'd0;
        end else if (addr == ADDR_DEBUGGEE_ERR) begin
          rec.rd = dbg_err_r;
        end else begin
          if (!inh_r) begin
            err_nxt = err_r | BIT_UNIBUS_NXM;
          end
        end
      end
      CMD_WRITE: begin
        priority if (addr == ADDR_INT_STATUS) begin
          int_nxt = (int_r & ~MASK_LOW_WRITE) | (data & MASK_LOW_WRITE);
        end else if (addr == ADDR_INT_HIGH) begin
          int_nxt = (int_r & ~MASK_HIGH_WRITE) | (data & MASK_HIGH_WRITE);
        end else if (addr == ADDR_ERR_STATUS) begin
          err_nxt     = '0;
          dbg_err_nxt = '0;
        end else if (addr == ADDR_DATA) begin
          rec.act0 = ACT_REMOTE_WR;
          rec.val0 = data;
          if (rok && ({hab_r, wa_r, 1'b0} == ADDR_ERR_STATUS)) begin
            dbg_err_nxt = '0;
          end
        end else if (addr == ADDR_REMOTE_CMD) begin
          rec.act0 = ACT_REMOTE_CMD;
          rec.val0 = data;
        end else if (addr == ADDR_MODIFIER) begin
          hab_nxt = data[0];
          if (data[4] || data[3]) begin
            rec.val0 = {8'd0, data[15:8]};
            rec.val1 = {8'd0, data[15:8]};
            if (data[4] && data[3]) begin
              rec.act0 = ACT_MARK_DBGR;
              rec.act1 = ACT_MARK_DBGEE;
              rec.two  = 1'b1;
            end else begin
              rec.act0 = data[4] ? ACT_MARK_DBGR : ACT_MARK_DBGEE;
            end
          end else if (data[5]) begin
            rec.act0 = ACT_PING;
          end else begin
            rst_seen_nxt = data[1];
            if (rst_seen_r && !data[1]) begin
              rec.act0 = ACT_RESET_REQ;
              rec.act1 = ACT_INHIBIT_REQ;
              rec.val1 = {15'd0, data[2]};
              rec.two  = 1'b1;
            end else begin
              rec.act0 = ACT_INHIBIT_REQ;
              rec.val0 = {15'd0, data[2]};
            end
          end
        end else if (addr == ADDR_LOCAL_CMD) begin
          hab_nxt = hab_r;
        end else if (addr == ADDR_WORD_ADDR) begin
          wa_nxt = data;
        end else begin
          if (!inh_r) begin
            err_nxt = err_r | BIT_UNIBUS_NXM;
          end
        end
      end
      CMD_ERROR: begin
        if (kind == EK_XBUS_NXM && !inh_r) begin
          err_nxt = err_r | BIT_XBUS_NXM;
        end else if (kind == EK_UNIBUS_NXM && !inh_r) begin
          err_nxt = err_r | BIT_UNIBUS_NXM;
        end else if (kind == EK_MAP_ERROR) begin
          err_nxt = err_r | BIT_MAP_ERROR;
        end
      end
      CMD_DBG_STATUS: begin
        dbg_err_nxt = data;
      end
      CMD_NXM_INHIBIT: begin
        inh_nxt = data[0];
      end
      CMD_BUS_RESET: begin
        err_nxt      = '0;
        inh_nxt      = 1'b0;
        rst_seen_nxt = 1'b0;
        dbg_err_nxt  = '0;
        hab_nxt      = 1'b0;
        wa_nxt       = '0;
      end
      default: begin
        hab_nxt = hab_r;
      end
    endcase
    rec.raddr = {hab_nxt, wa_nxt, 1'b0};
    rec.err   = err_nxt;
    rec.intv  = int_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r      <= '0;
      dbg_err_r  <= '0;
      inh_r      <= 1'b0;
      rst_seen_r <= 1'b0;
      hab_r      <= 1'b0;
      wa_r       <= '0;
      int_r      <= '0;
    end else if (push.valid) begin
      err_r      <= err_nxt;
      dbg_err_r  <= dbg_err_nxt;
      inh_r      <= inh_nxt;
      rst_seen_r <= rst_seen_nxt;
      hab_r      <= hab_nxt;
      wa_r       <= wa_nxt;
      int_r      <= int_nxt;
    end
  end

  a_bus_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid && cmd == CMD_BUS_RESET |=> err_r == '0 && wa_r == '0 && !hab_r)
    else $error("bus reset did not clear state");

  a_dbg_status_load: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid && cmd == CMD_DBG_STATUS |=> dbg_err_r == $past(in_tdata[33:18]))
    else $error("debuggee status not loaded");

endmodule
`default_nettype wire

/* sv/bir_queue.sv */
// Record queue between the front end and the output stage.
`default_nettype none
module bir_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  bir_pkg::push_t push,
  output logic           q_ready,
  input  logic           pop,
  output bir_pkg::head_t head
);
  import bir_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rec_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign q_ready    = (cnt_r != CW'(DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.rec   = mem_r[rd_ptr_r];
  assign do_push    = push.valid && q_ready;
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.rec;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_cnt_push: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count did not advance on push");

endmodule
`default_nettype wire

/* sv/bir_back.sv */
// Output stage: hold one record and send its one or two result beats.
`default_nettype none
module bir_back (
  input  logic           clk,
  input  logic           rst_n,
  input  bir_pkg::head_t head,
  output logic           pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [71:0]    out_tdata,
  output logic [3:0]     out_tuser,
  output logic           out_tlast
);
  import bir_pkg::*;

  rec_t        ent_r;
  logic        bk_valid_r;
  logic        idx_r;
  logic        beat;
  logic        fin;
  logic [15:0] rval;

  assign beat = bk_valid_r && out_tready;
  assign fin  = beat && (!ent_r.two || idx_r);
  assign pop  = head.valid && (!bk_valid_r || fin);

  assign out_tvalid = bk_valid_r;
  assign out_tuser  = idx_r ? ent_r.act1 : ent_r.act0;
  assign rval       = idx_r ? ent_r.val1 : ent_r.val0;
  assign out_tlast  = !ent_r.two || idx_r;
  assign out_tdata  = {ent_r.intv, ent_r.err, ent_r.rd, rval, ent_r.raddr};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bk_valid_r <= 1'b0;
      idx_r      <= 1'b0;
    end else if (pop) begin
      bk_valid_r <= 1'b1;
      idx_r      <= 1'b0;
    end else if (fin) begin
      bk_valid_r <= 1'b0;
      idx_r      <= 1'b0;
    end else if (beat) begin
      idx_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ent_r <= head.rec;
    end
  end

  a_second_beat_pair: assert property (@(posedge clk) disable iff (!rst_n)
    bk_valid_r && idx_r |-> ent_r.two)
    else $error("second beat sent for a single-result record");

  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && idx_r)
    else $error("second beat of a pair lost");

endmodule
`default_nettype wire

/* sv/bus_interface_registers_unit.sv */
// Top level of the bus interface register block.
// An accepted input beat is written into the record queue and then loaded into the output
// stage register before its first result beat is offered.
// Throughput: one input beat per cycle while the queue has room; items with two results send
// two output beats, so the output port's one beat per cycle, while out_tready is high, sets
// the sustained rate. The record queue (QUEUE_DEPTH entries) lets input and output stall independently.
// Reset is synchronous, active low: clears all register state, the queue and the output stage.
`default_nettype none
module bus_interface_registers_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // address[17:0], data[33:18], error_kind[35:34], remote_data[51:36], remote_ok[52]
  input  logic [55:0] in_tdata,
  // command[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // remote_address[17:0], remote_value[33:18], read_data[49:34],
  // error_status[55:50], interrupt_value[71:56]
  output logic [71:0] out_tdata,
  // action[3:0]
  output logic [3:0]  out_tuser,
  output logic        out_tlast
);
  import bir_pkg::*;

  push_t push;
  head_t head;
  logic  q_ready;
  logic  pop;

  bir_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_ready   (q_ready),
    .push      (push)
  );

  bir_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .q_ready (q_ready),
    .pop     (pop),
    .head    (head)
  );

  bir_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

/* sim/bir_response_checker.sv */
// Watches both streams of the register block, predicts each response beat and compares.
`timescale 1ns / 100ps
module bir_response_checker
  import bir_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,
  input  logic [3:0]  out_tuser,
  input  logic        out_tlast,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    act_t        act;
    logic [17:0] raddr;
    logic [15:0] rval;
    logic [15:0] rdata;
    logic [5:0]  err;
    logic [15:0] intv;
    logic        last;
  } resp_t;

  resp_t       pending_responses[$];
  resp_t       want;
  int          errors = 0;

  logic [5:0]  err_bits;
  logic [15:0] dbg_errs;
  logic        inhibit_nxm;
  logic        rst_seen;
  logic        hi_bit;
  logic [15:0] word_addr;
  logic [15:0] int_stat;

  assign mismatches = errors;

  task automatic report(input string msg);
    errors++;
    if (errors <= 40) $display("%0t ns  ERROR  %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [17:0] got,
                             input logic [17:0] exp_val);
    if (got !== exp_val)
      report($sformatf("%s: got %h, want %h", name, got, exp_val));
  endtask

  function automatic void flag_nxm(input logic [5:0] bits);
    if (!inhibit_nxm) err_bits = err_bits | bits;
  endfunction

  function automatic void compute_reg_response(input logic [2:0] op, input logic [17:0] addr,
                                               input logic [15:0] data, input logic [1:0] kind,
                                               input logic [15:0] rdata, input logic rok);
    act_t        act [2];
    logic [15:0] val [2];
    logic [15:0] rd;
    int          n;
    resp_t       r;
    act[0] = ACT_NONE;
    act[1] = ACT_NONE;
    val[0] = '0;
    val[1] = '0;
    rd = '0;
    n = 1;
    case (op)
      CMD_READ: begin
        if (addr == ADDR_INT_STATUS) rd = int_stat;
        else if (addr == ADDR_ERR_STATUS) rd = {10'b0, err_bits};
        else if (addr == ADDR_DATA) begin
          act[0] = ACT_REMOTE_RD;
          rd = rok ? rdata : 16'h0;
        end else if (addr == ADDR_DEBUGGEE_ERR) rd = dbg_errs;
        else flag_nxm(BIT_UNIBUS_NXM);
      end
      CMD_WRITE: begin
        case (addr)
          ADDR_INT_STATUS:
            int_stat = (int_stat & ~MASK_LOW_WRITE) | (data & MASK_LOW_WRITE);
          ADDR_INT_HIGH:
            int_stat = (int_stat & ~MASK_HIGH_WRITE) | (data & MASK_HIGH_WRITE);
          ADDR_ERR_STATUS: begin
            err_bits = '0;
            dbg_errs = '0;
          end
          ADDR_DATA: begin
            act[0] = ACT_REMOTE_WR;
            val[0] = data;
            if (rok && {hi_bit, word_addr, 1'b0} == ADDR_ERR_STATUS) dbg_errs = '0;
          end
          ADDR_REMOTE_CMD: begin
            act[0] = ACT_REMOTE_CMD;
            val[0] = data;
          end
          ADDR_MODIFIER: begin
            hi_bit = data[0];
            if (data[4] || data[3]) begin
              n = 0;
              if (data[4]) begin
                act[n] = ACT_MARK_DBGR;
                val[n] = {8'h00, data[15:8]};
                n++;
              end
              if (data[3]) begin
                act[n] = ACT_MARK_DBGEE;
                val[n] = {8'h00, data[15:8]};
                n++;
              end
            end else if (data[5]) begin
              act[0] = ACT_PING;
            end else begin
              n = 0;
              if (rst_seen && !data[1]) begin
                act[n] = ACT_RESET_REQ;
                n++;
              end
              rst_seen = data[1];
              act[n] = ACT_INHIBIT_REQ;
              val[n] = {15'b0, data[2]};
              n++;
            end
          end
          ADDR_LOCAL_CMD: ;
          ADDR_WORD_ADDR: word_addr = data;
          default: flag_nxm(BIT_UNIBUS_NXM);
        endcase
      end
      CMD_ERROR: begin
        if (kind == EK_XBUS_NXM) flag_nxm(BIT_XBUS_NXM);
        else if (kind == EK_UNIBUS_NXM) flag_nxm(BIT_UNIBUS_NXM);
        else if (kind == EK_MAP_ERROR) err_bits = err_bits | BIT_MAP_ERROR;
      end
      CMD_DBG_STATUS: dbg_errs = data;
      CMD_NXM_INHIBIT: inhibit_nxm = data[0];
      CMD_BUS_RESET: begin
        err_bits = '0;
        inhibit_nxm = 1'b0;
        rst_seen = 1'b0;
        dbg_errs = '0;
        hi_bit = 1'b0;
        word_addr = '0;
      end
      default: ;
    endcase
    for (int k = 0; k < n; k++) begin
      r.act = act[k];
      r.raddr = {hi_bit, word_addr, 1'b0};
      r.rval = val[k];
      r.rdata = rd;
      r.err = err_bits;
      r.intv = int_stat;
      r.last = (k == n - 1);
      pending_responses.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      err_bits = '0;
      dbg_errs = '0;
      inhibit_nxm = 1'b0;
      rst_seen = 1'b0;
      hi_bit = 1'b0;
      word_addr = '0;
      int_stat = '0;
      pending_responses.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_responses.size() == 0) begin
          report($sformatf("response beat with nothing pending: tuser %h tdata %h",
                           out_tuser, out_tdata));
        end else begin
          want = pending_responses.pop_front();
          check_field("action", out_tuser, want.act);
          check_field("remote_address", out_tdata[17:0], want.raddr);
          check_field("remote_value", out_tdata[33:18], want.rval);
          check_field("read_data", out_tdata[49:34], want.rdata);
          check_field("error_status", out_tdata[55:50], want.err);
          check_field("interrupt_value", out_tdata[71:56], want.intv);
          check_field("tlast", out_tlast, want.last);
        end
      end
      if (in_tvalid && in_tready)
        compute_reg_response(in_tuser, in_tdata[17:0], in_tdata[33:18], in_tdata[35:34],
                             in_tdata[51:36], in_tdata[52]);
    end
    outstanding <= pending_responses.size();
  end

endmodule

/* sim/bus_interface_registers_unit_tb.sv */
// Stimulus, stall profiles and verdict for the bus interface register block.
`timescale 1ns / 100ps
module bus_interface_registers_unit_tb;
  import bir_pkg::*;

  localparam logic [2:0] CMD_UNDEF_6 = 3'd6;
  localparam logic [2:0] CMD_UNDEF_7 = 3'd7;
  localparam logic [1:0] EK_UNUSED   = 2'd3;
  localparam int         ITEMS_PER_PHASE = 484;
  localparam int         STALL_LIMIT = 1000;
  localparam int         TAIL_CYCLES = 10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;

  int mismatches;
  int outstanding;
  int src_idle = 0;
  int sink_idle = 0;
  int idle_cycles = 0;
  int in_beats = 0;
  int out_beats = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bus_interface_registers_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  bir_response_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_idle);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (in_tvalid && in_tready) in_beats <= in_beats + 1;
      if (out_tvalid && out_tready) out_beats <= out_beats + 1;
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("stalled for %0d cycles with %0d responses pending", idle_cycles, outstanding);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_access(input logic [2:0] op, input logic [17:0] addr,
                             input logic [15:0] wdata, input logic [1:0] kind,
                             input logic [15:0] rdata, input logic rok);
    if ($urandom_range(99) < src_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {3'b000, rok, rdata, kind, wdata, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain_responses();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [17:0] pick_addr();
    if ($urandom_range(99) < 25) return 18'($urandom_range(0, 18'h3FFFF));
    case ($urandom_range(10))
      0: return ADDR_INT_STATUS;
      1: return ADDR_INT_HIGH;
      2: return ADDR_ERR_STATUS;
      3: return ADDR_DATA;
      4: return ADDR_REMOTE_CMD;
      5: return ADDR_DEBUGGEE_ERR;
      6: return ADDR_LOCAL_CMD;
      7: return ADDR_WORD_ADDR;
      default: return ADDR_MODIFIER;
    endcase
  endfunction

  task automatic send_random_access();
    int          r;
    logic [2:0]  op;
    logic [17:0] a;
    logic [15:0] d;
    r = $urandom_range(99);
    if (r < 30) op = CMD_READ;
    else if (r < 68) op = CMD_WRITE;
    else if (r < 78) op = CMD_ERROR;
    else if (r < 84) op = CMD_DBG_STATUS;
    else if (r < 90) op = CMD_NXM_INHIBIT;
    else if (r < 94) op = CMD_BUS_RESET;
    else if (r < 97) op = CMD_UNDEF_6;
    else op = CMD_UNDEF_7;
    a = pick_addr();
    d = 16'($urandom_range(0, 16'hFFFF));
    if (a == ADDR_MODIFIER && $urandom_range(1)) d[5:3] = 3'b000;
    if (a == ADDR_WORD_ADDR && $urandom_range(3) == 0) d = ADDR_ERR_STATUS[16:1];
    send_access(op, a, d, 2'($urandom_range(3)), 16'($urandom_range(0, 16'hFFFF)),
                1'($urandom_range(1)));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_access(CMD_WRITE, ADDR_INT_STATUS, 16'hFFFF, EK_XBUS_NXM, 16'h0000, 1'b0);
    send_access(CMD_WRITE, ADDR_INT_HIGH, 16'hFFFF, EK_XBUS_NXM, 16'h0000, 1'b0);
    send_access(CMD_READ, 18'h00000, 16'h0000, EK_XBUS_NXM, 16'h0000, 1'b0);
    send_access(CMD_READ, ADDR_INT_HIGH, 16'h0000, EK_XBUS_NXM, 16'h0000, 1'b0);
    send_access(CMD_WRITE, 18'h3FFFF, 16'h0000, EK_XBUS_NXM, 16'h0000, 1'b0);
    send_access(CMD_ERROR, 18'h00000, 16'h0000, EK_XBUS_NXM, 16'h0000, 1'b0);
    send_access(CMD_ERROR, 18'h00000, 16'h0000, EK_MAP_ERROR, 16'h0000, 1'b0);
    send_access(CMD_ERROR, 18'h00000, 16'h0000, EK_UNUSED, 16'h0000, 1'b0);
    send_access(CMD_WRITE, ADDR_ERR_STATUS, 16'h0000, EK_XBUS_NXM, 16'h0000, 1'b0);
    send_access(CMD_NXM_INHIBIT, 18'h00000, 16'h0001, EK_XBUS_NXM, 16'h0000, 1'b0);
    send_access(CMD_READ, 18'h3FFFF, 16'h0000, EK_XBUS_NXM, 16'h0000, 1'b0);
    send_access(CMD_ERROR, 18'h00000, 16'h0000, EK_XBUS_NXM, 16'h0000, 1'b0);
    send_access(CMD_ERROR, 18'h00000, 16'h0000, EK_MAP_ERROR, 16'h0000, 1'b0);
    send_access(CMD_NXM_INHIBIT, 18'h00000, 16'hFFFE, EK_XBUS_NXM, 16'h0000, 1'b0);
    send_access(CMD_DBG_STATUS, 18'h00000, 16'hFFFF, EK_XBUS_NXM, 16'h0000, 1'b0);
    send_access(CMD_WRITE, ADDR_WORD_ADDR, ADDR_ERR_STATUS[16:1], EK_XBUS_NXM,
                16'h0000, 1'b0);
    send_access(CMD_WRITE, ADDR_MODIFIER, 16'h0001, EK_XBUS_NXM, 16'h0000, 1'b0);
    send_access(CMD_WRITE, ADDR_DATA, 16'hFFFF, EK_XBUS_NXM, 16'h0000, 1'b1);
    send_access(CMD_READ, ADDR_DATA, 16'h0000, EK_XBUS_NXM, 16'hFFFF, 1'b0);
    send_access(CMD_WRITE, ADDR_REMOTE_CMD, 16'hFFFF, EK_XBUS_NXM, 16'h0000, 1'b0);
    send_access(CMD_WRITE, ADDR_MODIFIER, 16'hAB18, EK_XBUS_NXM, 16'h0000, 1'b0);
    send_access(CMD_WRITE, ADDR_MODIFIER, 16'h0020, EK_XBUS_NXM, 16'h0000, 1'b0);
    send_access(CMD_WRITE, ADDR_MODIFIER, 16'h0006, EK_XBUS_NXM, 16'h0000, 1'b0);
    send_access(CMD_WRITE, ADDR_MODIFIER, 16'h0004, EK_XBUS_NXM, 16'h0000, 1'b0);
    send_access(CMD_WRITE, ADDR_LOCAL_CMD, 16'hFFFF, EK_XBUS_NXM, 16'h0000, 1'b0);
    send_access(CMD_UNDEF_7, 18'h3FFFF, 16'hFFFF, EK_UNUSED, 16'hFFFF, 1'b1);
    send_access(CMD_BUS_RESET, 18'h00000, 16'h0000, EK_XBUS_NXM, 16'h0000, 1'b0);
    drain_responses();

    src_idle = 12;
    sink_idle = 48;
    repeat (ITEMS_PER_PHASE) send_random_access();
    drain_responses();

    src_idle = 48;
    sink_idle = 12;
    repeat (ITEMS_PER_PHASE) send_random_access();
    drain_responses();

    src_idle = 0;
    sink_idle = 0;
    repeat (ITEMS_PER_PHASE) send_random_access();
    drain_responses();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d input beats and %0d response beats over three stall profiles",
             in_beats, out_beats);
    $display("%0d field mismatches", mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* bus_interface_registers_unit.f */
sv/bir_pkg.sv
sv/bir_front.sv
sv/bir_queue.sv
sv/bir_back.sv
sv/bus_interface_registers_unit.sv
sim/bir_response_checker.sv
sim/bus_interface_registers_unit_tb.sv
